### src/brms_pkg.sv
// Shared types and constants for the block RMS with mean removal.
`default_nettype none

package brms_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned RMS_W      = 30;
  localparam int unsigned MCNT_W     = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Square of a 16-bit sample, magnitude of the mean, serial multiply length
  localparam int unsigned SQ_W       = 31;
  localparam int unsigned MMAG_W     = 16;
  localparam int unsigned MUL_STEPS  = MMAG_W;
  localparam int unsigned FRAC_W     = 16;

  localparam logic [RMS_W-1:0] RMS_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REMOVE_MEAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_COUNT  = 2'd2;

  typedef struct packed {
    logic              remove_mean;
    logic              normalize;
    logic [MCNT_W-1:0] mean_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{remove_mean: 1'b1, normalize: 1'b1,
                                 mean_count: 13'd512};

  // One finished block result
  typedef struct packed {
    logic [RMS_W-1:0] rms;
    logic             overflow;
  } res_t;

endpackage

`default_nettype wire

### src/brms_fin.sv
// Block-end finisher: bit-serial mean divide, shift-add multiplies, normalize
// divide and square root, sharing one divider.
`default_nettype none

module brms_fin #(
  parameter int unsigned CNT_W = 13
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          start_i,
  input  brms_pkg::cfg_t                               cfg_i,
  input  wire  [brms_pkg::SQ_W+CNT_W-2:0]              s2_i,
  input  wire  [brms_pkg::SAMPLE_W+CNT_W-1:0]          s1_i,
  input  wire  [brms_pkg::SAMPLE_W+CNT_W-1:0]          sf_i,
  input  wire  [CNT_W-1:0]                             n_i,
  input  wire                                          ovf_i,
  input  wire                                          take_i,
  output logic                                         busy_o,
  output logic                                         res_vld_o,
  output brms_pkg::res_t                               res_o
);
  import brms_pkg::*;

  localparam int unsigned SW   = SAMPLE_W + CNT_W;     // signed sums
  localparam int unsigned QW   = SQ_W + CNT_W - 1;     // sum of squares
  localparam int unsigned PW   = 32 + CNT_W;           // products, total
  localparam int unsigned UW   = SW + 2;               // 2*S1 - n*m
  localparam int unsigned TSW  = PW + 1;               // signed total
  localparam int unsigned EW   = PW + FRAC_W;          // radicand
  localparam int unsigned RW   = (EW + 1) / 2;         // root
  localparam int unsigned RADW = 2 * RW;
  localparam int unsigned RMW  = RW + 2;               // root remainder
  localparam int unsigned CTW  = $clog2(EW);
  localparam int unsigned MCW  = (CNT_W > MCNT_W) ? CNT_W : MCNT_W;
  localparam int unsigned RXW  = (RW > RMS_W) ? RW : RMS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_MEAN, S_MUL_NM, S_U_CALC, S_MUL_MU, S_TOTAL,
    S_DIV_NORM, S_SQRT, S_DONE
  } state_e;

  state_e              state_q;
  logic [CTW-1:0]      cnt_q;
  logic [QW-1:0]       s2_q;
  logic [SW-1:0]       s1_q;
  logic [CNT_W-1:0]    n_q;
  logic                ovf_q;
  logic                msgn_q;
  logic                usgn_q;
  logic [MMAG_W-1:0]   mmag_q;
  logic [EW-1:0]       div_q;
  logic [CNT_W-1:0]    rem_q;
  logic [CNT_W-1:0]    dvs_q;
  logic [PW-1:0]       prod_q;
  logic [PW-1:0]       mcand_q;
  logic [MMAG_W-1:0]   mplier_q;
  logic [RADW-1:0]     rad_q;
  logic [RMW-1:0]      sq_rem_q;
  logic [RW-1:0]       root_q;

  // Start: magnitude of the first-section sum and its sample count
  logic [SW-1:0]       sf_mag;
  logic [CNT_W-1:0]    nfirst;
  logic                use_mean;
  assign sf_mag   = sf_i[SW-1] ? (~sf_i + SW'(1)) : sf_i;
  assign nfirst   = (MCW'(n_i) < MCW'(cfg_i.mean_count)) ? n_i : CNT_W'(cfg_i.mean_count);
  assign use_mean = cfg_i.remove_mean && (nfirst != '0);

  // Restoring divider step, one quotient bit per cycle
  logic [CNT_W:0]      rem_s;
  logic                div_ge;
  logic [CNT_W-1:0]    rem_d;
  logic [EW-1:0]       div_d;
  assign rem_s  = {rem_q, div_q[EW-1]};
  assign div_ge = rem_s >= {1'b0, dvs_q};
  assign rem_d  = div_ge ? CNT_W'(rem_s - {1'b0, dvs_q}) : CNT_W'(rem_s);
  assign div_d  = {div_q[EW-2:0], div_ge};

  // Shift-add multiplier step, one multiplier bit per cycle
  logic [PW-1:0]       prod_d;
  assign prod_d = prod_q + (mplier_q[0] ? mcand_q : '0);

  // u = 2*S1 - n*m, from the finished n*|m| product
  logic [UW-1:0]       s1x;
  logic [UW-1:0]       nmx;
  logic [UW-1:0]       u;
  logic [UW-1:0]       umag;
  assign s1x  = {{2{s1_q[SW-1]}}, s1_q};
  assign nmx  = UW'(prod_q);
  assign u    = {s1x[UW-2:0], 1'b0} - (msgn_q ? (~nmx + UW'(1)) : nmx);
  assign umag = u[UW-1] ? (~u + UW'(1)) : u;

  // total = S2 - m*u, clamped at zero, then scaled by 2^16
  logic [TSW-1:0]      s2x;
  logic [TSW-1:0]      px;
  logic [TSW-1:0]      tot;
  logic [PW-1:0]       tot_mag;
  logic [EW-1:0]       e;
  assign s2x     = TSW'(s2_q);
  assign px      = TSW'(prod_q);
  assign tot     = (msgn_q ^ usgn_q) ? (s2x + px) : (s2x - px);
  assign tot_mag = tot[TSW-1] ? '0 : tot[PW-1:0];
  assign e       = {tot_mag, {FRAC_W{1'b0}}};

  // Square root step, two radicand bits per cycle
  logic [RMW+1:0]      sq_s;
  logic [RMW+1:0]      trial;
  logic                sq_ge;
  logic [RMW-1:0]      sq_rem_d;
  logic [RW-1:0]       root_d;
  assign sq_s     = {sq_rem_q, rad_q[RADW-1 -: 2]};
  assign trial    = (RMW+2)'({root_q, 2'b01});
  assign sq_ge    = sq_s >= trial;
  assign sq_rem_d = sq_ge ? RMW'(sq_s - trial) : RMW'(sq_s);
  assign root_d   = {root_q[RW-2:0], sq_ge};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      s2_q     <= '0;
      s1_q     <= '0;
      n_q      <= '0;
      ovf_q    <= 1'b0;
      msgn_q   <= 1'b0;
      usgn_q   <= 1'b0;
      mmag_q   <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      dvs_q    <= '0;
      prod_q   <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      rad_q    <= '0;
      sq_rem_q <= '0;
      root_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            s2_q    <= s2_i;
            s1_q    <= s1_i;
            n_q     <= n_i;
            ovf_q   <= ovf_i;
            msgn_q  <= sf_i[SW-1];
            // no mean: divide zero by one
            div_q   <= use_mean ? EW'(sf_mag) : '0;
            dvs_q   <= use_mean ? nfirst : CNT_W'(1);
            rem_q   <= '0;
            cnt_q   <= CTW'(EW - 1);
            state_q <= S_DIV_MEAN;
          end
        end
        S_DIV_MEAN: begin
          div_q <= div_d;
          rem_q <= rem_d;
          if (cnt_q == '0) begin
            mmag_q   <= div_d[MMAG_W-1:0];
            mplier_q <= div_d[MMAG_W-1:0];
            mcand_q  <= PW'(n_q);
            prod_q   <= '0;
            cnt_q    <= CTW'(MUL_STEPS - 1);
            state_q  <= S_MUL_NM;
          end else begin
            cnt_q <= cnt_q - CTW'(1);
          end
        end
        S_MUL_NM: begin
          prod_q   <= prod_d;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q - CTW'(1);
          if (cnt_q == '0) begin
            state_q <= S_U_CALC;
          end
        end
        S_U_CALC: begin
          usgn_q   <= u[UW-1];
          mcand_q  <= PW'(umag);
          mplier_q <= mmag_q;
          prod_q   <= '0;
          cnt_q    <= CTW'(MUL_STEPS - 1);
          state_q  <= S_MUL_MU;
        end
        S_MUL_MU: begin
          prod_q   <= prod_d;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q - CTW'(1);
          if (cnt_q == '0) begin
            state_q <= S_TOTAL;
          end
        end
        S_TOTAL: begin
          if (cfg_i.normalize) begin
            // empty block guard: divide zero by one
            div_q   <= (n_q != '0) ? e : '0;
            dvs_q   <= (n_q != '0) ? n_q : CNT_W'(1);
            rem_q   <= '0;
            cnt_q   <= CTW'(EW - 1);
            state_q <= S_DIV_NORM;
          end else begin
            rad_q    <= RADW'(e);
            sq_rem_q <= '0;
            root_q   <= '0;
            cnt_q    <= CTW'(RW - 1);
            state_q  <= S_SQRT;
          end
        end
        S_DIV_NORM: begin
          div_q <= div_d;
          rem_q <= rem_d;
          if (cnt_q == '0) begin
            rad_q    <= RADW'(div_d);
            sq_rem_q <= '0;
            root_q   <= '0;
            cnt_q    <= CTW'(RW - 1);
            state_q  <= S_SQRT;
          end else begin
            cnt_q <= cnt_q - CTW'(1);
          end
        end
        S_SQRT: begin
          rad_q    <= rad_q << 2;
          sq_rem_q <= sq_rem_d;
          root_q   <= root_d;
          cnt_q    <= cnt_q - CTW'(1);
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result, saturated to the rms field
  logic [RXW-1:0] root_x;
  assign root_x       = RXW'(root_q);
  assign res_o.rms    = (root_x > RXW'(RMS_MAX)) ? RMS_MAX : root_x[RMS_W-1:0];
  assign res_o.overflow = ovf_q;
  assign res_vld_o    = (state_q == S_DONE);
  assign busy_o       = (state_q != S_IDLE);

endmodule

`default_nettype wire

### src/block_rms_with_mean_removal_top.sv
// Top level of the block RMS with mean removal: sample accumulation,
// configuration registers and result register.
//
//   channel  direction  handshake                fields
//   in       sink       in_valid_i / in_stall_o  sample_i, last_i
//   out      source     out_valid_o / out_stall_i rms_o, overflow_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Samples are taken one per cycle; each passes a register, a squaring stage
// and the accumulators. A final sample starts the finisher once it has passed
// the sample and square registers; the finisher's bit-serial divider works on
// EW = 48 + clog2(MAX_SAMPLES+1) bits, its root unit yields RW = ceil(EW/2)
// bits, and the normalize divide is skipped with normalize off. Samples of the
// next block are taken meanwhile; only its final beat is stalled until the
// finisher is free. Reset is asynchronous and clears counts, accumulators and
// control, and loads the register defaults.
`default_nettype none

module block_rms_with_mean_removal_top #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  signed [brms_pkg::SAMPLE_W-1:0] sample_i,
  input  wire                                 last_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [brms_pkg::RMS_W-1:0]          rms_o,
  output logic                                overflow_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [brms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [brms_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import brms_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = SAMPLE_W + CNT_W;
  localparam int unsigned SQS_W = SQ_W + CNT_W - 1;
  localparam int unsigned MCW   = (CNT_W > MCNT_W) ? CNT_W : MCNT_W;

  cfg_t cfg_q;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_REMOVE_MEAN: cfg_q.remove_mean <= cfg_data_i[0];
        REG_NORMALIZE:   cfg_q.normalize   <= cfg_data_i[0];
        REG_MEAN_COUNT:  cfg_q.mean_count  <= cfg_data_i[MCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage: count, overflow and first-section flag
  logic [CNT_W-1:0] count_q;
  logic             ovf_q;
  logic [CNT_W-1:0] lastn_q;
  logic             lastovf_q;
  logic             fin_busy;
  logic             in_fire;
  logic             take;
  logic             first;
  logic [CNT_W-1:0] count_d;
  logic             ovf_d;

  logic                      a_vld_q, a_take_q, a_first_q, a_last_q;
  logic signed [SAMPLE_W-1:0] a_x_q;
  logic                      b_vld_q, b_take_q, b_first_q, b_last_q;
  logic [SAMPLE_W-1:0]       b_x_q;
  logic [SQ_W-1:0]           b_sq_q;

  // only a final beat waits, while an earlier block is still in flight
  assign in_stall_o = last_i & (fin_busy | (a_vld_q & a_last_q) | (b_vld_q & b_last_q));
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign take       = count_q < CNT_W'(MAX_SAMPLES);
  assign first      = take && (MCW'(count_q) < MCW'(cfg_q.mean_count));
  assign count_d    = take ? (count_q + CNT_W'(1)) : count_q;
  assign ovf_d      = ovf_q | ~take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      lastn_q   <= '0;
      lastovf_q <= 1'b0;
    end else if (in_fire) begin
      if (last_i) begin
        count_q   <= '0;
        ovf_q     <= 1'b0;
        lastn_q   <= count_d;
        lastovf_q <= ovf_d;
      end else begin
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  // Sample register, then square register
  logic signed [2*SAMPLE_W-1:0] a_prod;
  assign a_prod = a_x_q * a_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      a_take_q  <= 1'b0;
      a_first_q <= 1'b0;
      a_last_q  <= 1'b0;
      b_vld_q   <= 1'b0;
      b_take_q  <= 1'b0;
      b_first_q <= 1'b0;
      b_last_q  <= 1'b0;
    end else begin
      a_vld_q <= in_fire;
      if (in_fire) begin
        a_take_q  <= take;
        a_first_q <= first;
        a_last_q  <= last_i;
      end
      b_vld_q <= a_vld_q;
      if (a_vld_q) begin
        b_take_q  <= a_take_q;
        b_first_q <= a_first_q;
        b_last_q  <= a_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_x_q <= sample_i;
    end
    if (a_vld_q) begin
      b_x_q  <= a_x_q;
      b_sq_q <= a_prod[SQ_W-1:0];
    end
  end

  // Accumulators; a final beat hands the sums over and clears them
  logic [SQS_W-1:0] acc_s2_q, acc_s2_d;
  logic [SUM_W-1:0] acc_s1_q, acc_s1_d;
  logic [SUM_W-1:0] acc_sf_q, acc_sf_d;
  logic [SUM_W-1:0] bx_ext;
  logic             b_add;
  logic             fin_start;

  assign bx_ext    = {{CNT_W{b_x_q[SAMPLE_W-1]}}, b_x_q};
  assign b_add     = b_vld_q & b_take_q;
  assign acc_s2_d  = acc_s2_q + (b_add ? SQS_W'(b_sq_q) : '0);
  assign acc_s1_d  = acc_s1_q + (b_add ? bx_ext : '0);
  assign acc_sf_d  = acc_sf_q + ((b_add & b_first_q) ? bx_ext : '0);
  assign fin_start = b_vld_q & b_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_s2_q <= '0;
      acc_s1_q <= '0;
      acc_sf_q <= '0;
    end else if (b_vld_q) begin
      if (b_last_q) begin
        acc_s2_q <= '0;
        acc_s1_q <= '0;
        acc_sf_q <= '0;
      end else begin
        acc_s2_q <= acc_s2_d;
        acc_s1_q <= acc_s1_d;
        acc_sf_q <= acc_sf_d;
      end
    end
  end

  // Block-end finisher
  logic fin_vld;
  logic out_free;
  res_t fin_res;

  brms_fin #(
    .CNT_W (CNT_W)
  ) u_fin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (fin_start),
    .cfg_i     (cfg_q),
    .s2_i      (acc_s2_d),
    .s1_i      (acc_s1_d),
    .sf_i      (acc_sf_d),
    .n_i       (lastn_q),
    .ovf_i     (lastovf_q),
    .take_i    (out_free),
    .busy_o    (fin_busy),
    .res_vld_o (fin_vld),
    .res_o     (fin_res)
  );

  // Output register, reloaded in the cycle it is taken
  logic             out_vld_q;
  logic [RMS_W-1:0] rms_q;
  logic             out_ovf_q;

  assign out_free = ~out_vld_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_vld && out_free) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_vld && out_free) begin
      rms_q     <= fin_res.rms;
      out_ovf_q <= fin_res.overflow;
    end
  end

  assign out_valid_o = out_vld_q;
  assign rms_o       = rms_q;
  assign overflow_o  = out_ovf_q;

endmodule

`default_nettype wire

### src/brms_chk.sv
// Port-level checks for the block RMS top level, with its bind.
`default_nettype none

module brms_chk (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_stall_o,
  input wire                          last_i,
  input wire                          out_valid_o,
  input wire                          out_stall_i,
  input wire [brms_pkg::RMS_W-1:0]    rms_o,
  input wire                          overflow_o,
  input wire                          cfg_valid_i,
  input wire                          cfg_ready_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rms_o) && $stable(overflow_o))
    else $error("result beat changed while stalled");

  // only a final beat is ever stalled
  a_stall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> last_i)
    else $error("non-final sample stalled");

  // two final beats never enter in consecutive cycles
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> (!last_i || in_stall_o))
    else $error("final beat accepted while a block end is in flight");

  // the finisher is still busy: no result right after a final beat
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a final beat");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

endmodule

bind block_rms_with_mean_removal_top brms_chk u_brms_chk (.*);

`default_nettype wire

### dv/block_rms_with_mean_removal_top_tb.sv
// Testbench for the block RMS with mean removal: directed, random and backpressure tests.
`timescale 1ns / 1ps

module block_rms_with_mean_removal_top_tb;
  import brms_pkg::*;

  localparam int unsigned MAX_SAMPLES = 4096;
  // finisher length (divider + root) plus pipeline, with margin
  localparam int unsigned EW          = 48 + $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SETTLE_CYC  = 2 * EW + (EW + 1) / 2 + 36 + 40;
  localparam int unsigned CYCLE_LIMIT = 800_000;
  localparam int unsigned HOLD_CYC    = 1500;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;

  typedef enum int unsigned {MIX_FULL, MIX_NEAR, MIX_EDGE, MIX_SMALL} mix_e;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic signed [SAMPLE_W-1:0]  sample_i    = '0;
  logic                        last_i      = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [RMS_W-1:0]            rms_o;
  logic                        overflow_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = REG_REMOVE_MEAN;
  logic [CFG_DATA_W-1:0]       cfg_data_i  = '0;

  // predictor state: configuration and block accumulators
  cfg_t        model_cfg;
  longint      acc_sum;
  longint      acc_first;
  longint      acc_sq;
  int unsigned acc_n;
  logic        acc_ovf;

  res_t        rms_exp_q[$];
  res_t        want;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_left    = 0;

  block_rms_with_mean_removal_top #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rms_o       (rms_o),
    .overflow_o  (overflow_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // long hold-off of the result side, counted here
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left <= hold_req;
      hold_req = 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result-side stall: hold-off or random
  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // result check against the oldest expected beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rms_exp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual rms %0d overflow %0b",
                 $time, rms_o, overflow_o);
        mismatch_cnt++;
      end else begin
        want = rms_exp_q.pop_front();
        if (rms_o !== want.rms) begin
          $display("%0t: rms mismatch: expected %0d, actual %0d", $time, want.rms, rms_o);
          mismatch_cnt++;
        end
        if (overflow_o !== want.overflow) begin
          $display("%0t: overflow mismatch: expected %0b, actual %0b",
                   $time, want.overflow, overflow_o);
          mismatch_cnt++;
        end
      end
    end
  end

  function automatic void clear_block_model();
    acc_sum   = 0;
    acc_first = 0;
    acc_sq    = 0;
    acc_n     = 0;
    acc_ovf   = 1'b0;
  endfunction

  // floor square root, one result bit per step from the top
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // accumulate one accepted sample; on the final one, queue the expected RMS
  function automatic void rms_predict_sample(input logic signed [SAMPLE_W-1:0] value,
                                             input logic is_last);
    longint          x;
    longint          n;
    longint          nf;
    longint          m;
    longint          total;
    longint unsigned e;
    longint unsigned root;
    res_t            res;
    x = value;
    if (acc_n < MAX_SAMPLES) begin
      acc_sum += x;
      acc_sq  += x * x;
      if (acc_n < model_cfg.mean_count) acc_first += x;
      acc_n++;
    end else begin
      acc_ovf = 1'b1;
    end
    if (!is_last) return;
    n  = acc_n;
    nf = (acc_n < model_cfg.mean_count) ? acc_n : model_cfg.mean_count;
    m  = 0;
    // mean truncates toward zero
    if (model_cfg.remove_mean && nf > 0) m = acc_first / nf;
    total = acc_sq - 2 * m * acc_sum + n * m * m;
    if (total < 0) total = 0;
    e = unsigned'(total) << FRAC_W;
    if (model_cfg.normalize) e = (n > 0) ? e / unsigned'(n) : 0;
    root = floor_sqrt(e);
    if (root > RMS_MAX) root = RMS_MAX;
    res.rms      = root[RMS_W-1:0];
    res.overflow = acc_ovf;
    rms_exp_q.push_back(res);
    clear_block_model();
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input mix_e mix, input int center);
    int v;
    case (mix)
      MIX_FULL: v = int'($urandom_range(65535)) - 32768;
      MIX_NEAR: v = center + int'($urandom_range(512)) - 256;
      MIX_EDGE: begin
        case ($urandom_range(3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(64)) - 32;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    last_i     <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rms_predict_sample(value, is_last);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_block(input int unsigned len, input mix_e mix);
    int center;
    center = int'($urandom_range(65535)) - 32768;
    for (int unsigned k = 0; k < len; k++) send_sample(pick_sample(mix, center), k == len - 1);
  endtask

  // wait for every expected result, then for the finisher to drain
  task automatic wait_settled();
    while (rms_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_REMOVE_MEAN: model_cfg.remove_mean = value[0];
      REG_NORMALIZE:   model_cfg.normalize   = value[0];
      REG_MEAN_COUNT:  model_cfg.mean_count  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // flag registers get random upper bits, only bit 0 counts
  task automatic set_config(input logic rm, input logic nm, input logic [CFG_DATA_W-1:0] mc);
    logic [CFG_DATA_W-1:0] word;
    word    = CFG_DATA_W'($urandom);
    word[0] = rm;
    write_reg(REG_REMOVE_MEAN, word);
    word    = CFG_DATA_W'($urandom);
    word[0] = nm;
    write_reg(REG_NORMALIZE, word);
    write_reg(REG_MEAN_COUNT, mc);
  endtask

  task automatic load_random_config();
    logic [CFG_DATA_W-1:0] mc;
    case ($urandom_range(7))
      0:       mc = '0;
      1:       mc = CFG_DATA_W'(1);
      2:       mc = CFG_DATA_W'(512);
      3:       mc = CFG_DATA_W'(MAX_SAMPLES);
      4:       mc = '1;
      5:       mc = CFG_DATA_W'($urandom);
      default: mc = CFG_DATA_W'($urandom_range(64, 2));
    endcase
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), mc);
  endtask

  // mixed-extreme block: with a mean count of two, the odd mean over two samples truncates to zero
  task automatic run_edge_block();
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(16'sh0101, 1'b1);
    release_input();
    wait_settled();
  endtask

  // reset configuration: single-sample blocks, extremes, constant block
  task automatic test_defaults();
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shFFFF, 1'b1);
    // mean removed from a constant block leaves zero
    repeat (3) send_sample(16'sd1000, 1'b0);
    send_sample(16'sd1000, 1'b1);
    release_input();
    wait_settled();
  endtask

  // register extremes, including zero and oversized mean counts
  task automatic test_config_extremes();
    write_reg(REG_SPARE, '1);
    run_edge_block();
    set_config(1'b0, 1'b0, 13'd1);
    run_edge_block();
    set_config(1'b1, 1'b0, 13'd0);
    run_edge_block();
    set_config(1'b1, 1'b1, '1);
    run_edge_block();
    set_config(1'b1, 1'b0, 13'd2);
    run_edge_block();
  endtask

  // random blocks under one configuration and one idle and stall profile
  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input int unsigned n_items);
    int unsigned sent;
    int unsigned blocks;
    int unsigned len;
    idle_pct  = 0;
    stall_pct = 0;
    load_random_config();
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    blocks    = 0;
    while (sent < n_items || blocks < 12) begin
      len = ($urandom_range(24) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
      send_block(len, mix_e'($urandom_range(3)));
      sent += len;
      blocks++;
    end
    release_input();
    wait_settled();
  endtask

  // result side held off while short blocks keep coming
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_req = HOLD_CYC;
    for (int unsigned b = 0; b < 30; b++) send_block(2, MIX_FULL);
    release_input();
    wait_settled();
  endtask

  initial begin
    model_cfg = CFG_RESET;
    clear_block_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_config_extremes();
    test_random_phase(0, 0, 280);
    test_random_phase(60, 0, 280);
    test_random_phase(0, 60, 280);
    test_random_phase(30, 30, 280);
    test_backpressure();
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
src/brms_pkg.sv
src/brms_fin.sv
src/block_rms_with_mean_removal_top.sv
src/brms_chk.sv
dv/block_rms_with_mean_removal_top_tb.sv
